[src/chg_pkg.sv]
// Shared types, widths and constant tables of the core-count hotplug governor.
// Used by chg_ctrl, chg_dp, core_count_hotplug_governor_core and the testbench; no dependencies.
package chg_pkg;

  localparam int unsigned FracBitsDef = 11;
  localparam int unsigned NumCores    = 4;

  localparam int unsigned OpW      = 2;
  localparam int unsigned AvgW     = 20;
  localparam int unsigned DepthW   = 10;
  localparam int unsigned CoresW   = 3;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned PeriodW  = 7;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned BusyW    = 16;
  localparam int unsigned ThrW     = 5;
  localparam int unsigned DivSteps = CfgW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [PeriodW-1:0] PeriodRst = PeriodW'(10);
  localparam logic [MaskW-1:0]   AllSecMask =
      MaskW'(((1 << NumCores) - 1) & ~1);

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_SUSPEND = 2'd1,
    OP_RESUME  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_FULL     = 2'd0,
    MODE_ECO      = 2'd1,
    MODE_STRICT   = 2'd2,
    MODE_FULL_ALT = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 3'd0,
    CFG_IDLE_PERIOD = 3'd1,
    CFG_BUSY_PERIOD = 3'd2,
    CFG_HOLD_TWO    = 3'd3,
    CFG_HOLD_THREE  = 3'd4,
    CFG_HOLD_FOUR   = 3'd5,
    CFG_BUSY_HOLD   = 3'd6,
    CFG_HOLD_DIV    = 3'd7
  } cfg_idx_e;

  // Run-queue depth limits and busy-time limits, indexed by core pair slot.
  localparam logic [4:0] DepthLim [8] = '{5'd19, 5'd30, 5'd19, 5'd11,
                                          5'd19, 5'd11, 5'd0,  5'd11};
  localparam logic [7:0] TimeLim  [8] = '{8'd140, 8'd0, 8'd140, 8'd190,
                                          8'd140, 8'd190, 8'd0, 8'd190};

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

[src/chg_ctrl.sv]
// Sequencer of the hotplug governor: handshakes and the step order of one item.
// Depends on chg_pkg for the command and status structs.
module chg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  chg_pkg::sts_t sts_i,
  output chg_pkg::cmd_t cmd_o
);
  import chg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.drop) begin
          state_d = S_IDLE;
        end else if (sts_i.need_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the output register to empty
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EVAL))
    else $error("accepted item did not enter evaluation");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a stalled item");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_o)
    else $error("published result not presented");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_OUT))
    else $error("division end did not lead to output");

endmodule

[src/chg_dp.sv]
// Datapath of the hotplug governor: configuration, governor state, level and
// boost decision, serial hold divider and the output register. Uses chg_pkg.
module chg_dp #(
  parameter int unsigned FracBits = chg_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [chg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [chg_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic [chg_pkg::OpW-1:0]        op_i,
  input  logic [chg_pkg::AvgW-1:0]       avg_threads_i,
  input  logic [chg_pkg::DepthW-1:0]     queue_depth_i,
  input  logic [chg_pkg::CoresW-1:0]     cores_online_i,
  input  logic [chg_pkg::ElapsedW-1:0]   elapsed_ms_i,
  input  chg_pkg::cmd_t                  cmd_i,
  output chg_pkg::sts_t                  sts_o,
  output logic [chg_pkg::MaskW-1:0]      up_mask_o,
  output logic [chg_pkg::MaskW-1:0]      down_mask_o,
  output logic [chg_pkg::PeriodW-1:0]    next_period_ms_o,
  output logic [chg_pkg::LevelW-1:0]     thread_level_o,
  output logic                           boost_o
);
  import chg_pkg::*;

  localparam int unsigned CmpW = AvgW + FracBits;

  // configuration
  mode_e              mode_q;
  logic [CfgW-1:0]    idle_per_q, busy_per_q, hold_two_q, hold_three_q;
  logic [CfgW-1:0]    hold_four_q, busy_hold_q, hold_div_q;

  // governor state
  logic [LevelW-1:0]  prev_lvl_q, prev_lvl_d;
  logic [BusyW-1:0]   busy_time_q, busy_time_d;
  logic [CfgW-1:0]    hold_q;
  logic [CfgW-1:0]    busy_cnt_q, busy_cnt_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic               susp_q, susp_d;

  // captured item
  op_e                op_q;
  logic [AvgW-1:0]    avg_q;
  logic [DepthW-1:0]  depth_q;
  logic [CoresW-1:0]  cores_q;
  logic [ElapsedW-1:0] elapsed_q;

  // evaluation results
  logic [MaskW-1:0]   res_up_q, res_up_d, res_down_q, res_down_d;
  logic [LevelW-1:0]  res_lvl_q, res_lvl_d;
  logic               res_boost_q, res_boost_d;
  logic [CfgW-1:0]    hold_new_q, hold_new_d;
  logic               hold_wr_q, hold_wr_d;
  logic               div_used_q;

  // divider
  logic [CfgW-1:0]    rem_q, quo_q, dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic [CfgW:0]      trial;
  logic               trial_ge;

  // output register
  logic [MaskW-1:0]   out_up_q, out_down_q;
  logic [PeriodW-1:0] out_per_q;
  logic [LevelW-1:0]  out_lvl_q;
  logic               out_boost_q;

  // ---------------- level from thread average ----------------
  logic              is_full, is_eco, is_strict;
  logic [ThrW-1:0]   t1, t2, t3;
  logic [CmpW-1:0]   avg_x, s1, s2, s3;
  logic              le1, le2, le3;
  logic [LevelW-1:0] level;

  assign is_strict = (mode_q == MODE_STRICT);
  assign is_eco    = (mode_q == MODE_ECO);
  assign is_full   = (mode_q == MODE_FULL) || (mode_q == MODE_FULL_ALT);

  assign t1 = (is_eco ? ThrW'(3) : ThrW'(5)) +
              ((prev_lvl_q <= LevelW'(1)) ? (is_eco ? ThrW'(4) : ThrW'(8)) : ThrW'(0));
  assign t2 = ThrW'(7) + ((prev_lvl_q <= LevelW'(2)) ? ThrW'(8) : ThrW'(0));
  assign t3 = ThrW'(9) + ((prev_lvl_q <= LevelW'(3)) ? ThrW'(8) : ThrW'(0));

  assign avg_x = CmpW'(avg_q);
  assign s1 = is_full ? (CmpW'(t1) << (FracBits - 3)) : (CmpW'(t1) << (FracBits - 1));
  assign s2 = CmpW'(t2) << (FracBits - 3);
  assign s3 = CmpW'(t3) << (FracBits - 3);
  assign le1 = (avg_x <= s1);
  assign le2 = (avg_x <= s2);
  assign le3 = (avg_x <= s3);

  always_comb begin
    priority if (is_strict || le1) begin
      level = LevelW'(1);
    end else if (is_eco || le2) begin
      level = LevelW'(2);
    end else if (le3) begin
      level = LevelW'(3);
    end else begin
      level = LevelW'(4);
    end
  end

  // ---------------- run-queue boost ----------------
  logic [2:0]       slot;
  logic [BusyW:0]   bt_sum;
  logic [BusyW-1:0] bt_sat;
  logic             boost_en, fire, bt_clear;
  logic [LevelW-1:0] count;

  assign boost_en = is_full && (cores_q >= CoresW'(1)) && (cores_q < CoresW'(4));
  assign slot     = {cores_q[1:0] - 2'd1, 1'b0};
  assign bt_sum   = {1'b0, busy_time_q} + (BusyW + 1)'(elapsed_q);
  assign bt_sat   = bt_sum[BusyW] ? {BusyW{1'b1}} : bt_sum[BusyW-1:0];
  assign fire     = boost_en && (depth_q >= DepthW'(DepthLim[slot])) &&
                    (bt_sat >= BusyW'(TimeLim[slot]));
  // clear only while depth sits between the down and up limits
  assign bt_clear = (depth_q < DepthW'(DepthLim[slot])) &&
                    (depth_q > DepthW'(DepthLim[slot | 3'd1]));

  always_comb begin
    count = level;
    if (fire && cores_q == CoresW'(2)) begin
      count = LevelW'(3);
    end else if (fire && cores_q == CoresW'(3)) begin
      count = LevelW'(4);
    end
  end

  // ---------------- item evaluation ----------------
  logic [CfgW-1:0] hold_dec, hold_pick;
  logic            tick, need_div;

  assign tick     = (op_q == OP_TICK);
  assign hold_dec = (hold_q == '0) ? '0 : hold_q - CfgW'(1);
  assign need_div = tick && !susp_q && (count >= LevelW'(2)) && !fire &&
                    (hold_div_q > CfgW'(1));

  always_comb begin
    unique case (count)
      LevelW'(2): hold_pick = hold_two_q;
      LevelW'(3): hold_pick = hold_three_q;
      default:    hold_pick = hold_four_q;
    endcase
  end

  always_comb begin
    prev_lvl_d  = prev_lvl_q;
    busy_time_d = busy_time_q;
    busy_cnt_d  = busy_cnt_q;
    period_d    = period_q;
    susp_d      = susp_q;
    res_up_d    = '0;
    res_down_d  = '0;
    res_lvl_d   = LevelW'(1);
    res_boost_d = 1'b0;
    hold_new_d  = hold_q;
    hold_wr_d   = 1'b0;
    unique case (op_q)
      OP_SUSPEND: begin
        susp_d     = 1'b1;
        res_down_d = AllSecMask;
      end
      OP_RESUME: begin
        susp_d     = 1'b0;
        hold_new_d = busy_hold_q;
        hold_wr_d  = 1'b1;
        if (is_strict) begin
          res_up_d = '0;
        end else if (is_eco) begin
          res_up_d = MaskW'(4'h2);
        end else begin
          res_up_d = AllSecMask;
        end
      end
      OP_TICK: begin
        prev_lvl_d  = level;
        res_lvl_d   = level;
        res_boost_d = fire;
        if (boost_en) begin
          busy_time_d = bt_clear ? '0 : bt_sat;
        end
        if (count > LevelW'(2)) begin
          if (busy_cnt_q == '0) begin
            period_d   = busy_per_q;
            busy_cnt_d = busy_hold_q;
          end
        end else if (busy_cnt_q != '0) begin
          busy_cnt_d = busy_cnt_q - CfgW'(1);
        end else begin
          period_d = idle_per_q;
        end
        if (!susp_q) begin
          hold_wr_d = 1'b1;
          unique case (count)
            LevelW'(1): begin
              hold_new_d = hold_dec;
              if (hold_dec == '0) res_down_d = MaskW'(4'hE);
            end
            LevelW'(2): begin
              hold_new_d = hold_pick;
              if (cores_q < CoresW'(2)) res_up_d = MaskW'(4'h2);
              else res_down_d = MaskW'(4'hC);
            end
            LevelW'(3): begin
              hold_new_d = hold_pick;
              if (cores_q < CoresW'(3)) res_up_d = MaskW'(4'h6);
              else res_down_d = MaskW'(4'h8);
            end
            default: begin
              hold_new_d = hold_pick;
              if (cores_q < CoresW'(4)) res_up_d = MaskW'(4'hE);
            end
          endcase
        end
      end
      default: begin
        // unknown op: drop, nothing changes
      end
    endcase
  end

  assign sts_o.drop     = (op_q == OP_NONE);
  assign sts_o.need_div = need_div;
  assign sts_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // ---------------- restoring divider, one quotient bit a cycle ----------------
  assign trial    = {rem_q, quo_q[CfgW-1]};
  assign trial_ge = (trial >= {1'b0, dvs_q});

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_FULL;
      idle_per_q   <= CfgW'(40);
      busy_per_q   <= CfgW'(20);
      hold_two_q   <= CfgW'(7);
      hold_three_q <= CfgW'(5);
      hold_four_q  <= CfgW'(3);
      busy_hold_q  <= CfgW'(10);
      hold_div_q   <= CfgW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:        mode_q       <= mode_e'(cfg_wdata_i[ModeW-1:0]);
        CFG_IDLE_PERIOD: idle_per_q   <= cfg_wdata_i;
        CFG_BUSY_PERIOD: busy_per_q   <= cfg_wdata_i;
        CFG_HOLD_TWO:    hold_two_q   <= cfg_wdata_i;
        CFG_HOLD_THREE:  hold_three_q <= cfg_wdata_i;
        CFG_HOLD_FOUR:   hold_four_q  <= cfg_wdata_i;
        CFG_BUSY_HOLD:   busy_hold_q  <= cfg_wdata_i;
        CFG_HOLD_DIV:    hold_div_q   <= cfg_wdata_i;
        default:         mode_q       <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lvl_q  <= '0;
      busy_time_q <= '0;
      busy_cnt_q  <= '0;
      period_q    <= PeriodRst;
      susp_q      <= 1'b0;
      hold_q      <= '0;
    end else begin
      if (cmd_i.eval) begin
        prev_lvl_q  <= prev_lvl_d;
        busy_time_q <= busy_time_d;
        busy_cnt_q  <= busy_cnt_d;
        period_q    <= period_d;
        susp_q      <= susp_d;
      end
      // hold count lands with the result, after any division
      if (cmd_i.publish && hold_wr_q) begin
        hold_q <= div_used_q ? quo_q : hold_new_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(op_i);
      avg_q     <= avg_threads_i;
      depth_q   <= queue_depth_i;
      cores_q   <= cores_online_i;
      elapsed_q <= elapsed_ms_i;
    end
    if (cmd_i.eval) begin
      res_up_q    <= res_up_d;
      res_down_q  <= res_down_d;
      res_lvl_q   <= res_lvl_d;
      res_boost_q <= res_boost_d;
      hold_new_q  <= hold_new_d;
      hold_wr_q   <= hold_wr_d;
      div_used_q  <= need_div;
      rem_q       <= '0;
      quo_q       <= hold_new_d;
      dvs_q       <= hold_div_q;
      cnt_q       <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? CfgW'(trial - {1'b0, dvs_q}) : trial[CfgW-1:0];
      quo_q <= {quo_q[CfgW-2:0], trial_ge};
      cnt_q <= cnt_q + DivCntW'(1);
    end
    if (cmd_i.publish) begin
      out_up_q    <= res_up_q;
      out_down_q  <= res_down_q;
      out_per_q   <= period_q;
      out_lvl_q   <= res_lvl_q;
      out_boost_q <= res_boost_q;
    end
  end

  assign up_mask_o        = out_up_q;
  assign down_mask_o      = out_down_q;
  assign next_period_ms_o = out_per_q;
  assign thread_level_o   = out_lvl_q;
  assign boost_o          = out_boost_q;

endmodule

[src/core_count_hotplug_governor_core.sv]
// Top level of the core-count hotplug governor: sequencer plus datapath.
// Depends on chg_pkg, chg_ctrl and chg_dp.
//
//   port group   direction  handshake                 payload
//   cfg          in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in           in         in_valid_i / in_stall_o   op, avg_threads, queue_depth,
//                                                     cores_online, elapsed_ms
//   out          out        out_valid_o / out_stall_i up_mask, down_mask,
//                                                     next_period_ms, thread_level, boost
//
// One item at a time: accept, evaluate, then the result is staged.
// A tick that reloads a hold count divided by hold_divisor (above one) passes
// through the serial divider, one quotient bit a cycle.
// An unknown op is dropped after its evaluation and yields no result.
// The next item is taken while a result waits in the output register; a stalled
// output holds its result, and the item after it then waits with the input stalled.
// Reset is asynchronous.
module core_count_hotplug_governor_core #(
  parameter int unsigned FracBits = chg_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [chg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [chg_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [chg_pkg::OpW-1:0]        op_i,
  input  logic [chg_pkg::AvgW-1:0]       avg_threads_i,
  input  logic [chg_pkg::DepthW-1:0]     queue_depth_i,
  input  logic [chg_pkg::CoresW-1:0]     cores_online_i,
  input  logic [chg_pkg::ElapsedW-1:0]   elapsed_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [chg_pkg::MaskW-1:0]      up_mask_o,
  output logic [chg_pkg::MaskW-1:0]      down_mask_o,
  output logic [chg_pkg::PeriodW-1:0]    next_period_ms_o,
  output logic [chg_pkg::LevelW-1:0]     thread_level_o,
  output logic                           boost_o
);
  import chg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  chg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  chg_dp #(
    .FracBits (FracBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .avg_threads_i    (avg_threads_i),
    .queue_depth_i    (queue_depth_i),
    .cores_online_i   (cores_online_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .up_mask_o        (up_mask_o),
    .down_mask_o      (down_mask_o),
    .next_period_ms_o (next_period_ms_o),
    .thread_level_o   (thread_level_o),
    .boost_o          (boost_o)
  );

endmodule

[test/core_count_hotplug_governor_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for core_count_hotplug_governor_core: directed table, then random
// phases under several register settings, results compared with typed table rows or an in-bench predictor.
// Depends on chg_pkg and the governor RTL only.
module core_count_hotplug_governor_core_tb;
  import chg_pkg::*;

  localparam int unsigned FRAC         = FracBitsDef;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF     = 300;

  // thread thresholds with and without hysteresis, both scales
  localparam int unsigned THR_POINTS [8] = '{3 << (FRAC - 1), 7 << (FRAC - 1),
                                            5 << (FRAC - 3), 7 << (FRAC - 3),
                                            9 << (FRAC - 3), 13 << (FRAC - 3),
                                            15 << (FRAC - 3), 17 << (FRAC - 3)};
  localparam int unsigned FULL_THR   [3] = '{5, 7, 9};
  // boost limits per online core count 1..3
  localparam int unsigned FIRE_DEPTH [3] = '{19, 19, 19};
  localparam int unsigned CLR_DEPTH  [3] = '{30, 11, 11};
  localparam int unsigned FIRE_TIME  [3] = '{140, 140, 140};

  typedef struct packed {
    op_e                 op;
    logic [AvgW-1:0]     avg;
    logic [DepthW-1:0]   depth;
    logic [CoresW-1:0]   cores;
    logic [ElapsedW-1:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [MaskW-1:0]   up;
    logic [MaskW-1:0]   down;
    logic [PeriodW-1:0] period;
    logic [LevelW-1:0]  level;
    logic               boost;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } row_t;

  localparam result_t NO_RES = '0;

  localparam row_t DIR_TAB [24] = '{
    '{'{OP_SUSPEND, 20'd0, 10'd0, 3'd1, 16'd0}, 1'b1, '{4'h0, 4'hE, 7'd10, 3'd1, 1'b0}},
    '{'{OP_RESUME, 20'd0, 10'd0, 3'd1, 16'd0}, 1'b1, '{4'hE, 4'h0, 7'd10, 3'd1, 1'b0}},
    '{'{OP_NONE, 20'hFFFFF, 10'h3FF, 3'd7, 16'hFFFF}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'd0, 3'd0, 16'd0}, 1'b1, '{4'h0, 4'h0, 7'd40, 3'd1, 1'b0}},
    '{'{OP_TICK, 20'hFFFFF, 10'h3FF, 3'd4, 16'hFFFF}, 1'b1, '{4'h0, 4'h0, 7'd20, 3'd4, 1'b0}},
    '{'{OP_TICK, 20'd0, 10'd19, 3'd2, 16'd140}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'd15, 3'd2, 16'd5}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'd11, 3'd3, 16'hFFFF}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'd0, 3'd1, 16'hFFFF}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'h3FF, 3'd3, 16'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'd30, 3'd1, 16'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'h3FF, 3'd5, 16'd100}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd1280, 10'd25, 3'd7, 16'd9}, 1'b0, NO_RES},
    '{'{OP_SUSPEND, 20'hFFFFF, 10'h3FF, 3'd7, 16'hFFFF}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd4352, 10'd19, 3'd1, 16'd200}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd0, 10'd0, 3'd2, 16'd0}, 1'b0, NO_RES},
    '{'{OP_RESUME, 20'd0, 10'd0, 3'd0, 16'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd3329, 10'd0, 3'd1, 16'd1}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd3328, 10'd12, 3'd2, 16'd1}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd1281, 10'd18, 3'd3, 16'd1}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'd1280, 10'd31, 3'd4, 16'd1}, 1'b0, NO_RES},
    '{'{OP_NONE, 20'd0, 10'd0, 3'd0, 16'd0}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'hAAAAA, 10'h155, 3'd2, 16'h5555}, 1'b0, NO_RES},
    '{'{OP_TICK, 20'h55555, 10'h2AA, 3'd5, 16'hAAAA}, 1'b0, NO_RES}
  };

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [CfgW-1:0]     cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [OpW-1:0]      op_i           = '0;
  logic [AvgW-1:0]     avg_threads_i  = '0;
  logic [DepthW-1:0]   queue_depth_i  = '0;
  logic [CoresW-1:0]   cores_online_i = '0;
  logic [ElapsedW-1:0] elapsed_ms_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [MaskW-1:0]    up_mask_o;
  logic [MaskW-1:0]    down_mask_o;
  logic [PeriodW-1:0]  next_period_ms_o;
  logic [LevelW-1:0]   thread_level_o;
  logic                boost_o;

  // predictor copy of the registers and state
  mode_e       m_mode = MODE_FULL;
  int unsigned m_idle = 40, m_busy_per = 20, m_hold2 = 7, m_hold3 = 5, m_hold4 = 3;
  int unsigned m_busy_hold = 10, m_div = 2;
  int unsigned s_prev_level = 0, s_busy_time = 0, s_hold = 0, s_busy_cnt = 0, s_period = 10;
  bit          s_suspended = 1'b0;

  result_t     pending_results [$];
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_req  = 0;
  int unsigned hold_off_seen = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  result_t     got_res;
  result_t     want_res;

  core_count_hotplug_governor_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .avg_threads_i   (avg_threads_i),
    .queue_depth_i   (queue_depth_i),
    .cores_online_i  (cores_online_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .up_mask_o       (up_mask_o),
    .down_mask_o     (down_mask_o),
    .next_period_ms_o(next_period_ms_o),
    .thread_level_o  (thread_level_o),
    .boost_o         (boost_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned hold_after(input int unsigned h, input bit fired);
    return (fired || m_div == 0) ? h : h / m_div;
  endfunction

  // Advance the governor state by one item; return 0 when the item yields no result.
  function automatic bit governor_step(input item_t it, output result_t r);
    int unsigned lvl, cnt, lim, thr, hyst, shift, slot;
    bit          full, fired, done;
    logic [MaskW-1:0] up, dn;
    up    = '0;
    dn    = '0;
    lvl   = 1;
    fired = 1'b0;
    done  = 1'b0;
    r     = '0;
    full  = (m_mode == MODE_FULL) || (m_mode == MODE_FULL_ALT);
    if (it.op == OP_NONE) return 1'b0;
    if (it.op == OP_SUSPEND) begin
      s_suspended = 1'b1;
      dn = 4'b1110;
    end else if (it.op == OP_RESUME) begin
      s_hold = m_busy_hold;
      s_suspended = 1'b0;
      if (m_mode == MODE_STRICT) up = 4'b0000;
      else if (m_mode == MODE_ECO) up = 4'b0010;
      else up = 4'b1110;
    end else begin
      if (m_mode == MODE_STRICT) begin
        lim = 1; hyst = 2; shift = FRAC - 1;
      end else if (m_mode == MODE_ECO) begin
        lim = 2; hyst = 4; shift = FRAC - 1;
      end else begin
        lim = 4; hyst = 8; shift = FRAC - 3;
      end
      while (!done && lvl < lim) begin
        thr = (m_mode == MODE_ECO) ? 3 : FULL_THR[lvl - 1];
        if (s_prev_level <= lvl) thr += hyst;
        if (it.avg <= (thr << shift)) done = 1'b1;
        else lvl++;
      end
      s_prev_level = lvl;
      cnt = lvl;
      if (full && it.cores >= 1 && it.cores < 4) begin
        slot = int'(it.cores) - 1;
        s_busy_time += 32'(it.elapsed);
        if (s_busy_time > 65535) s_busy_time = 65535;
        if (it.depth >= FIRE_DEPTH[slot]) fired = (s_busy_time >= FIRE_TIME[slot]);
        else if (it.depth > CLR_DEPTH[slot]) s_busy_time = 0;
        if (fired && it.cores == 2) cnt = 3;
        else if (fired && it.cores == 3) cnt = 4;
      end
      if (cnt > 2) begin
        if (s_busy_cnt == 0) begin
          s_period = m_busy_per;
          s_busy_cnt = m_busy_hold;
        end
      end else if (s_busy_cnt > 0) begin
        s_busy_cnt--;
      end else begin
        s_period = m_idle;
      end
      if (!s_suspended) begin
        case (cnt)
          1: begin
            if (s_hold > 0) s_hold--;
            if (s_hold == 0) dn = 4'b1110;
          end
          2: begin
            s_hold = hold_after(m_hold2, fired);
            if (it.cores < 2) up = 4'b0010;
            else dn = 4'b1100;
          end
          3: begin
            s_hold = hold_after(m_hold3, fired);
            if (it.cores < 3) up = 4'b0110;
            else dn = 4'b1000;
          end
          default: begin
            s_hold = hold_after(m_hold4, fired);
            if (it.cores < 4) up = 4'b1110;
          end
        endcase
      end
    end
    r.up     = up;
    r.down   = dn;
    r.period = PeriodW'(s_period);
    r.level  = LevelW'(lvl);
    r.boost  = fired;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Offer one item and hold it until accepted; valid stays high on return.
  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= it.op;
    avg_threads_i  <= it.avg;
    queue_depth_i  <= it.depth;
    cores_online_i <= it.cores;
    elapsed_ms_i   <= it.elapsed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (governor_step(it, r)) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:        m_mode = mode_e'(val[ModeW-1:0]);
      CFG_IDLE_PERIOD: m_idle = 32'(val);
      CFG_BUSY_PERIOD: m_busy_per = 32'(val);
      CFG_HOLD_TWO:    m_hold2 = 32'(val);
      CFG_HOLD_THREE:  m_hold3 = 32'(val);
      CFG_HOLD_FOUR:   m_hold4 = 32'(val);
      CFG_BUSY_HOLD:   m_busy_hold = 32'(val);
      default:         m_div = 32'(val);
    endcase
  endtask

  // Drop valid, wait for every expected result, then let a dropped item finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_res = '{up_mask_o, down_mask_o, next_period_ms_o, thread_level_o, boost_o};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got_res);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("up_mask", 32'(want_res.up), 32'(got_res.up));
        check_field("down_mask", 32'(want_res.down), 32'(got_res.down));
        check_field("next_period_ms", 32'(want_res.period), 32'(got_res.period));
        check_field("thread_level", 32'(want_res.level), 32'(got_res.level));
        check_field("boost", 32'(want_res.boost), 32'(got_res.boost));
      end
    end
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_left = HOLD_OFF;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL core_count_hotplug_governor_core");
      $finish;
    end
  end

  initial begin
    item_t       it;
    mode_e       md;
    int unsigned vals [7];
    int unsigned pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 54;
    foreach (DIR_TAB[i]) send_item(DIR_TAB[i].it, DIR_TAB[i].typed, DIR_TAB[i].res);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 20 : (p < 6) ? 54 : 0;
      recv_idle_pct = (p < 3) ? 54 : (p < 6) ? 20 : 0;
      // order: idle, busy, hold two, hold three, hold four, busy hold, divisor
      case (p)
        0: begin
          md = MODE_FULL;
          vals = '{0, 100, 100, 100, 100, 100, 1};
        end
        1: begin
          md = MODE_ECO;
          vals = '{100, 0, 0, 0, 0, 0, 0};
        end
        default: begin
          md = (p == 2) ? MODE_STRICT : (p == 3) ? MODE_FULL_ALT :
               (p % 2 == 0) ? MODE_FULL : mode_e'($urandom_range(0, 3));
          foreach (vals[i]) vals[i] = $urandom_range(0, 100);
          if (p == 3) vals[6] = 100;
          else if ($urandom_range(1)) vals[6] = $urandom_range(0, 4);
        end
      endcase
      cfg_write(CFG_MODE, {5'($urandom_range(0, 31)), md});
      cfg_write(CFG_IDLE_PERIOD, CfgW'(vals[0]));
      cfg_write(CFG_BUSY_PERIOD, CfgW'(vals[1]));
      cfg_write(CFG_HOLD_TWO, CfgW'(vals[2]));
      cfg_write(CFG_HOLD_THREE, CfgW'(vals[3]));
      cfg_write(CFG_HOLD_FOUR, CfgW'(vals[4]));
      cfg_write(CFG_BUSY_HOLD, CfgW'(vals[5]));
      cfg_write(CFG_HOLD_DIV, CfgW'(vals[6]));
      cfg_we_i <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the output for a long stretch while items keep coming
        if ((p == 0 || p == 7) && n == 40) hold_off_req++;
        pick = $urandom_range(99);
        it.op = (pick < 80) ? OP_TICK : (pick < 88) ? OP_SUSPEND :
                (pick < 95) ? OP_RESUME : OP_NONE;
        pick = $urandom_range(99);
        if (pick < 40) it.avg = AvgW'(THR_POINTS[$urandom_range(7)] + $urandom_range(2) - 1);
        else if (pick < 85) it.avg = AvgW'($urandom_range(0, 5000));
        else it.avg = AvgW'($urandom());
        it.depth = ($urandom_range(99) < 75) ? DepthW'($urandom_range(0, 40))
                                             : DepthW'($urandom());
        it.cores = ($urandom_range(99) < 85) ? CoresW'($urandom_range(1, 4))
                                             : CoresW'($urandom_range(0, 7));
        pick = $urandom_range(99);
        if (pick < 70) it.elapsed = ElapsedW'($urandom_range(0, 200));
        else if (pick < 95) it.elapsed = ElapsedW'($urandom_range(0, 2000));
        else it.elapsed = ElapsedW'($urandom());
        send_item(it, 1'b0, NO_RES);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS core_count_hotplug_governor_core");
    end else begin
      $display("FAIL core_count_hotplug_governor_core");
    end
    $finish;
  end

endmodule

[core_count_hotplug_governor_core.f]
src/chg_pkg.sv
src/chg_ctrl.sv
src/chg_dp.sv
src/core_count_hotplug_governor_core.sv
test/core_count_hotplug_governor_core_tb.sv
